// File: hdl/mtd_pkg.sv
// Shared types and constants for the multichannel touch debouncer.
// No dependencies; used by the register file, the update logic and the top level.
package mtd_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CHAN_W   = 3;
  localparam int COUNT_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GROUND_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALID_CEILING    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LIMIT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_START      = 3'd4;

  // Reset values
  localparam logic [SAMPLE_W-1:0] GROUND_THRESHOLD_RST = 12'd100;
  localparam logic [SAMPLE_W-1:0] VALID_CEILING_RST    = 12'd4095;
  localparam logic [COUNT_W-1:0]  PRESS_LIMIT_RST      = 8'd3;
  localparam logic [COUNT_W-1:0]  RELEASE_LIMIT_RST    = 8'd3;
  localparam logic [COUNT_W-1:0]  COUNT_START_RST      = 8'd0;

  typedef struct packed {
    logic [SAMPLE_W-1:0] ground_threshold;
    logic [SAMPLE_W-1:0] valid_ceiling;
    logic [COUNT_W-1:0]  press_limit;
    logic [COUNT_W-1:0]  release_limit;
    logic [COUNT_W-1:0]  count_start;
  } cfg_t;

  typedef struct packed {
    logic               pressed;
    logic [COUNT_W-1:0] press_cnt;
    logic [COUNT_W-1:0] release_cnt;
  } chan_state_t;

  typedef struct packed {
    logic press_event;
    logic release_event;
  } events_t;

endpackage

// File: hdl/mtd_cfg_regs.sv
// Configuration register file for the touch debouncer.
// Depends on mtd_pkg for register indexes, reset values and cfg_t.
module mtd_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [mtd_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [mtd_pkg::CFG_DATA_W-1:0]     wr_data,
  output mtd_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ground_threshold <= mtd_pkg::GROUND_THRESHOLD_RST;
      cfg.valid_ceiling    <= mtd_pkg::VALID_CEILING_RST;
      cfg.press_limit      <= mtd_pkg::PRESS_LIMIT_RST;
      cfg.release_limit    <= mtd_pkg::RELEASE_LIMIT_RST;
      cfg.count_start      <= mtd_pkg::COUNT_START_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        mtd_pkg::REG_GROUND_THRESHOLD: cfg.ground_threshold <= wr_data;
        mtd_pkg::REG_VALID_CEILING:    cfg.valid_ceiling    <= wr_data;
        mtd_pkg::REG_PRESS_LIMIT:
          cfg.press_limit   <= wr_data[mtd_pkg::COUNT_W-1:0];
        mtd_pkg::REG_RELEASE_LIMIT:
          cfg.release_limit <= wr_data[mtd_pkg::COUNT_W-1:0];
        mtd_pkg::REG_COUNT_START:
          cfg.count_start   <= wr_data[mtd_pkg::COUNT_W-1:0];
        default: ; // unmapped index, write dropped
      endcase
    end
  end

endmodule

// File: hdl/mtd_chan_update.sv
// Per-channel debounce update: classify one sample, step the counters, flip state.
// Depends on mtd_pkg for cfg_t, chan_state_t and events_t.
module mtd_chan_update (
  input  mtd_pkg::cfg_t                  cfg,
  input  mtd_pkg::chan_state_t           cur,
  input  logic [mtd_pkg::SAMPLE_W-1:0]   sample,
  output mtd_pkg::chan_state_t           nxt,
  output mtd_pkg::events_t               ev
);

  logic                       touched;
  logic                       untouched;
  logic [mtd_pkg::COUNT_W-1:0] press_inc;
  logic [mtd_pkg::COUNT_W-1:0] release_inc;

  assign touched   = sample < cfg.ground_threshold;
  assign untouched = !touched && (sample <= cfg.valid_ceiling);

  // Saturating steps: never pass the limit
  assign press_inc   = (cur.press_cnt < cfg.press_limit) ?
                       cur.press_cnt + 8'd1 : cur.press_cnt;
  assign release_inc = (cur.release_cnt < cfg.release_limit) ?
                       cur.release_cnt + 8'd1 : cur.release_cnt;

  always_comb begin
    nxt = cur;
    ev  = '0;
    priority if (touched && !cur.pressed) begin
      nxt.press_cnt = press_inc;
      if (press_inc == cfg.press_limit) begin
        nxt.pressed     = 1'b1;
        nxt.release_cnt = cfg.count_start;
        ev.press_event  = 1'b1;
      end
    end else if (touched) begin
      nxt.release_cnt = cfg.count_start;
    end else if (untouched && cur.pressed) begin
      nxt.release_cnt = release_inc;
      if (release_inc == cfg.release_limit) begin
        nxt.pressed      = 1'b0;
        nxt.press_cnt    = cfg.count_start;
        ev.release_event = 1'b1;
      end
    end else if (untouched) begin
      nxt.press_cnt = cfg.count_start;
    end else begin
      nxt = cur; // reading above the ceiling: no change
    end
  end

endmodule

// File: hdl/multichannel_touch_debouncer.sv
// Top level of the multichannel touch debouncer.
// Depends on mtd_pkg, mtd_cfg_regs and mtd_chan_update.
//
// Counter-based debounce filter for up to CHANNELS touch channels. Each input
// request is one 12-bit converter sample tagged with its channel; each sample
// produces exactly one result request carrying the channel, its debounced
// state after the sample, and one-shot press/release event flags. Throughput
// is one sample per clock while the sink takes results. A sample accepted
// into the input register moves on to the result register once that register
// can drain or is empty, with the per-channel state written at the same edge
// as the result register so a sample for the same channel in the very next
// cycle already sees the update.
// Both channels use valid/ready; input ready stays high while the result
// register can drain or is empty. Samples whose channel is CHANNELS or above
// leave all state alone and report released with no events. Configuration
// registers (0 ground_threshold, 1 valid_ceiling, 2 press_limit,
// 3 release_limit, 4 count_start) are always ready and must be written only
// while no sample is in flight; other indexes are ignored. Reset releases
// every channel and clears all counters to the reset value of count_start.
module multichannel_touch_debouncer #(
  parameter int CHANNELS = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // sample input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mtd_pkg::CHAN_W-1:0]       channel,
  input  logic [mtd_pkg::SAMPLE_W-1:0]     sample,
  // result output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mtd_pkg::CHAN_W-1:0]       out_channel,
  output logic                             pressed,
  output logic                             press_event,
  output logic                             release_event,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mtd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mtd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W = 7; // holds any channel code and CHANNELS up to 127

  mtd_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  mtd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Input register
  logic                         s1_valid;
  logic [mtd_pkg::CHAN_W-1:0]   s1_channel;
  logic [mtd_pkg::SAMPLE_W-1:0] s1_sample;
  logic                         s1_advance;

  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_channel <= channel;
      s1_sample  <= sample;
    end
  end

  // Channel decode
  logic [EXT_W-1:0] ch_ext;
  logic             in_range;
  logic [IDX_W-1:0] ch_idx;

  assign ch_ext   = EXT_W'(s1_channel);
  assign in_range = ch_ext < EXT_W'(CHANNELS);
  assign ch_idx   = ch_ext[IDX_W-1:0];

  // Per-channel state, one entry per channel, read at the current channel
  logic                        pressed_flags    [CHANNELS];
  logic [mtd_pkg::COUNT_W-1:0] press_counters   [CHANNELS];
  logic [mtd_pkg::COUNT_W-1:0] release_counters [CHANNELS];

  mtd_pkg::chan_state_t cur_state;
  mtd_pkg::chan_state_t state_next;
  mtd_pkg::events_t     ev_next;

  always_comb begin
    cur_state = '0;
    if (in_range) begin
      cur_state.pressed     = pressed_flags[ch_idx];
      cur_state.press_cnt   = press_counters[ch_idx];
      cur_state.release_cnt = release_counters[ch_idx];
    end
  end

  mtd_chan_update u_update (
    .cfg    (cfg),
    .cur    (cur_state),
    .sample (s1_sample),
    .nxt    (state_next),
    .ev     (ev_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pressed_flags[i]    <= 1'b0;
        press_counters[i]   <= mtd_pkg::COUNT_START_RST;
        release_counters[i] <= mtd_pkg::COUNT_START_RST;
      end
    end else if (s1_advance && in_range) begin
      pressed_flags[ch_idx]    <= state_next.pressed;
      press_counters[ch_idx]   <= state_next.press_cnt;
      release_counters[ch_idx] <= state_next.release_cnt;
    end
  end

  // Result register; out-of-range channels report released, no events
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_channel   <= s1_channel;
      pressed       <= in_range && state_next.pressed;
      press_event   <= in_range && ev_next.press_event;
      release_event <= in_range && ev_next.release_event;
    end
  end

endmodule

// File: hdl/mtd_checker.sv
// Port-level checks for the multichannel touch debouncer, bound to the top level.
// Depends on mtd_pkg for field widths.
module mtd_checker #(
  parameter int CHANNELS = 8
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mtd_pkg::CHAN_W-1:0]       out_channel,
  input logic                             pressed,
  input logic                             press_event,
  input logic                             release_event
);

  localparam int EXT_W = 7;

  // A result request stalled by the sink must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(pressed)
      && $stable(press_event) && $stable(release_event))
    else $error("result changed while stalled");

  // Events agree with the reported state and never coincide
  a_press_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && press_event |-> pressed && !release_event)
    else $error("press event without pressed state");

  a_release_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && release_event |-> !pressed && !press_event)
    else $error("release event with pressed state");

  // Channels without state report released and quiet
  a_out_of_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (EXT_W'(out_channel) >= EXT_W'(CHANNELS))
      |-> !pressed && !press_event && !release_event)
    else $error("out-of-range channel reported activity");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind multichannel_touch_debouncer mtd_checker #(.CHANNELS(CHANNELS)) u_mtd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_channel   (out_channel),
  .pressed       (pressed),
  .press_event   (press_event),
  .release_event (release_event)
);

// File: tb/sv/mtd_checker.sv
// Result checker for the multichannel touch debouncer testbench.
// Depends on mtd_pkg; watches the sample, result and configuration channels.
// Predicts each result, queues it in order and compares accepted results.
module mtd_result_checker #(
  parameter int CHANNELS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [mtd_pkg::CHAN_W-1:0]     channel,
  input  logic [mtd_pkg::SAMPLE_W-1:0]   sample,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [mtd_pkg::CHAN_W-1:0]     out_channel,
  input  logic                           pressed,
  input  logic                           press_event,
  input  logic                           release_event,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [mtd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mtd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             results_owed,
  output int                             mismatches
);

  typedef struct packed {
    logic [mtd_pkg::CHAN_W-1:0] chan;
    logic                       pressed;
    logic                       press_ev;
    logic                       release_ev;
  } touch_result_t;

  mtd_pkg::cfg_t        thresholds;
  mtd_pkg::chan_state_t chan_st [CHANNELS];
  touch_result_t        expected_results [$];

  initial begin
    results_owed = 0;
    mismatches   = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR t=%0t %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Debounce update for one sample; updates the tracked channel state.
  task automatic debounce_predict(input logic [mtd_pkg::CHAN_W-1:0] ch,
                                  input logic [mtd_pkg::SAMPLE_W-1:0] s,
                                  output touch_result_t r);
    mtd_pkg::chan_state_t st;
    logic                 touched;
    logic                 untouched;
    r = '0;
    r.chan = ch;
    if (ch < CHANNELS) begin
      st        = chan_st[ch];
      touched   = s < thresholds.ground_threshold;
      untouched = !touched && (s <= thresholds.valid_ceiling);
      if (touched && !st.pressed) begin
        if (st.press_cnt < thresholds.press_limit) st.press_cnt = st.press_cnt + 1'b1;
        if (st.press_cnt == thresholds.press_limit) begin
          st.pressed     = 1'b1;
          st.release_cnt = thresholds.count_start;
          r.press_ev     = 1'b1;
        end
      end else if (touched) begin
        st.release_cnt = thresholds.count_start;
      end else if (untouched && st.pressed) begin
        if (st.release_cnt < thresholds.release_limit)
          st.release_cnt = st.release_cnt + 1'b1;
        if (st.release_cnt == thresholds.release_limit) begin
          st.pressed   = 1'b0;
          st.press_cnt = thresholds.count_start;
          r.release_ev = 1'b1;
        end
      end else if (untouched) begin
        st.press_cnt = thresholds.count_start;
      end
      chan_st[ch] = st;
      r.pressed   = st.pressed;
    end
  endtask

  always @(posedge clk) begin
    touch_result_t want;
    if (rst) begin
      thresholds.ground_threshold = mtd_pkg::GROUND_THRESHOLD_RST;
      thresholds.valid_ceiling    = mtd_pkg::VALID_CEILING_RST;
      thresholds.press_limit      = mtd_pkg::PRESS_LIMIT_RST;
      thresholds.release_limit    = mtd_pkg::RELEASE_LIMIT_RST;
      thresholds.count_start      = mtd_pkg::COUNT_START_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_st[i].pressed     = 1'b0;
        chan_st[i].press_cnt   = mtd_pkg::COUNT_START_RST;
        chan_st[i].release_cnt = mtd_pkg::COUNT_START_RST;
      end
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mtd_pkg::REG_GROUND_THRESHOLD: thresholds.ground_threshold = cfg_data;
          mtd_pkg::REG_VALID_CEILING:    thresholds.valid_ceiling    = cfg_data;
          mtd_pkg::REG_PRESS_LIMIT:
            thresholds.press_limit   = cfg_data[mtd_pkg::COUNT_W-1:0];
          mtd_pkg::REG_RELEASE_LIMIT:
            thresholds.release_limit = cfg_data[mtd_pkg::COUNT_W-1:0];
          mtd_pkg::REG_COUNT_START:
            thresholds.count_start   = cfg_data[mtd_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        debounce_predict(channel, sample, want);
        expected_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding, channel",
                          int'(out_channel), -1);
        end else begin
          want = expected_results.pop_front();
          if (out_channel !== want.chan)
            report_mismatch("out_channel", int'(out_channel), int'(want.chan));
          if (pressed !== want.pressed)
            report_mismatch($sformatf("pressed ch%0d", want.chan),
                            int'(pressed), int'(want.pressed));
          if (press_event !== want.press_ev)
            report_mismatch($sformatf("press_event ch%0d", want.chan),
                            int'(press_event), int'(want.press_ev));
          if (release_event !== want.release_ev)
            report_mismatch($sformatf("release_event ch%0d", want.chan),
                            int'(release_event), int'(want.release_ev));
        end
      end
    end
    results_owed <= expected_results.size();
  end

endmodule

// File: tb/sv/tb_top.sv
// Top of the multichannel touch debouncer testbench: clock, reset, stimulus, verdict.
// Depends on mtd_pkg, multichannel_touch_debouncer and mtd_result_checker.
module tb_top;

  localparam int CHANNELS      = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 128;
  localparam int LONG_STALL    = 300;
  localparam int DRAIN_CYCLES  = 4;    // two-stage pipe plus margin

  // What a generated reading is aimed at, given the current thresholds
  typedef enum int {READ_TOUCHED, READ_UNTOUCHED, READ_OVER_CEILING} reading_kind_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [mtd_pkg::CHAN_W-1:0]     channel = '0;
  logic [mtd_pkg::SAMPLE_W-1:0]   sample = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [mtd_pkg::CHAN_W-1:0]     out_channel;
  logic                           pressed;
  logic                           press_event;
  logic                           release_event;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [mtd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mtd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int results_owed;
  int mismatches;
  int cycle_count = 0;

  // Thresholds currently programmed, used to aim readings at each region
  int cur_gt = int'(mtd_pkg::GROUND_THRESHOLD_RST);
  int cur_vc = int'(mtd_pkg::VALID_CEILING_RST);

  // Back-to-back stretches for each side
  int tx_burst = 0;
  int rx_burst = 0;

  // Set by the stimulus to make the result side hold off for a long stretch
  bit stall_req = 1'b0;

  always #1 clk = ~clk;

  multichannel_touch_debouncer #(.CHANNELS(CHANNELS)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .channel(channel), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_channel(out_channel),
    .pressed(pressed), .press_event(press_event), .release_event(release_event),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  mtd_result_checker #(.CHANNELS(CHANNELS)) checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .channel(channel), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready), .out_channel(out_channel),
    .pressed(pressed), .press_event(press_event), .release_event(release_event),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .results_owed(results_owed), .mismatches(mismatches)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL multichannel_touch_debouncer");
      $finish;
    end
  end

  // Idle gap before the next request, drawn at random, with occasional runs of zero.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst = $urandom_range(10, 40);
    return $urandom_range(0, 10);
  endfunction

  // Result side. Ready is raised after a random gap and held until a request
  // is taken. Handshakes are checked at the falling edge, where both sides are
  // settled, and completed at the following rising edge.
  initial begin
    int gap;
    forever begin
      if (stall_req) begin
        // long hold-off: the pipe fills and in_ready must drop
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_req = 1'b0;
      end
      gap = draw_gap(rx_burst);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // One sample request. Valid stays high across back-to-back requests.
  task automatic send_sample(input logic [mtd_pkg::CHAN_W-1:0] ch,
                             input logic [mtd_pkg::SAMPLE_W-1:0] s);
    int gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    channel  <= ch;
    sample   <= s;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Stop offering samples and wait until every result has come back.
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [mtd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mtd_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Program all five registers. The 8-bit ones get junk in the unused upper
  // data bits, which the block must drop.
  task automatic set_thresholds(input int gt, input int vc, input int pl, input int rl,
                                input int cs);
    logic [3:0] junk;
    int         jr;
    jr   = $urandom_range(0, 15);
    junk = jr[3:0];
    write_reg(mtd_pkg::REG_GROUND_THRESHOLD, gt[11:0]);
    write_reg(mtd_pkg::REG_VALID_CEILING, vc[11:0]);
    write_reg(mtd_pkg::REG_PRESS_LIMIT, {junk, pl[7:0]});
    write_reg(mtd_pkg::REG_RELEASE_LIMIT, {~junk, rl[7:0]});
    write_reg(mtd_pkg::REG_COUNT_START, {junk ^ 4'h5, cs[7:0]});
    cur_gt = gt;
    cur_vc = vc;
  endtask

  // Reading inside the requested region, often on its edge. Falls back to a
  // fully random reading when the region is empty for these thresholds.
  function automatic logic [mtd_pkg::SAMPLE_W-1:0] pick_sample(input reading_kind_t k);
    int lo;
    int hi;
    int v;
    case (k)
      READ_TOUCHED: begin
        lo = 0;
        hi = cur_gt - 1;
      end
      READ_UNTOUCHED: begin
        lo = cur_gt;
        hi = cur_vc;
      end
      default: begin
        lo = (cur_gt > cur_vc + 1) ? cur_gt : cur_vc + 1;
        hi = 4095;
      end
    endcase
    if (lo > hi) begin
      v = $urandom_range(0, 4095);
    end else begin
      case ($urandom_range(0, 7))
        0:       v = lo;
        1:       v = hi;
        default: v = $urandom_range(lo, hi);
      endcase
    end
    return v[mtd_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic int pick_limit();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 255;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  initial begin
    int gt, vc, pl, rl, cs, sent, run_len, r, rch, rs;
    logic [mtd_pkg::CHAN_W-1:0] run_ch;
    reading_kind_t kind;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- Directed: reset thresholds (below 100 touched, limits 3) ---
    // ch0 full press then full release at the sample extremes
    repeat (3) send_sample(3'd0, 12'd0);
    repeat (3) send_sample(3'd0, 12'd4095);
    // ch7: a reading right at the ground threshold breaks the press count
    send_sample(3'd7, 12'd99);
    send_sample(3'd7, 12'd99);
    send_sample(3'd7, 12'd100);
    repeat (3) send_sample(3'd7, 12'd99);
    drain();

    // --- Zero limits: the first counting sample flips at once ---
    set_thresholds(2048, 3000, 0, 0, 0);
    send_sample(3'd3, 12'd3500);   // over the ceiling, ignored
    send_sample(3'd3, 12'd10);     // immediate press
    send_sample(3'd3, 12'd10);     // still touched while pressed
    send_sample(3'd3, 12'd3500);   // ignored while pressed
    send_sample(3'd3, 12'd2048);   // immediate release
    send_sample(3'd3, 12'd3000);   // untouched while released
    drain();

    // --- Overlapping thresholds, widest limits, start equal to limit ---
    set_thresholds(4095, 0, 255, 255, 255);
    send_sample(3'd1, 12'd2000);   // touched though above the ceiling
    send_sample(3'd1, 12'd4095);   // neither touched nor valid
    send_sample(3'd2, 12'd4094);
    drain();

    // --- Count start above the press limit: the counter sticks, no flip ---
    set_thresholds(4095, 4095, 5, 2, 200);
    send_sample(3'd2, 12'd4095);   // untouched, reloads the press counter to 200
    send_sample(3'd2, 12'd0);
    send_sample(3'd2, 12'd0);
    drain();

    // --- Random phases: mostly debounce runs on one channel, some noise ---
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      r  = $urandom_range(0, 9);
      gt = (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(50, 3000);
      r  = $urandom_range(0, 9);
      vc = (r == 0) ? $urandom_range(0, 4095) : (r < 3) ? 4095 : $urandom_range(gt, 4095);
      pl = pick_limit();
      rl = pick_limit();
      r  = $urandom_range(0, 9);
      cs = (r < 6) ? 0 : (r < 8) ? $urandom_range(0, 3) : (r == 8) ? 255 :
           $urandom_range(0, 255);
      set_thresholds(gt, vc, pl, rl, cs);
      // first random phase: make the block back up against a stalled output
      if (ph == 0) stall_req = 1'b1;

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        r       = $urandom_range(0, CHANNELS - 1);
        run_ch  = r[mtd_pkg::CHAN_W-1:0];
        r       = $urandom_range(0, 9);
        kind    = (r < 4) ? READ_TOUCHED : (r < 9) ? READ_UNTOUCHED : READ_OVER_CEILING;
        run_len = $urandom_range(1, 8);
        for (int i = 0; i < run_len && sent < PHASE_ITEMS; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            rch = $urandom_range(0, CHANNELS - 1);
            rs  = $urandom_range(0, 4095);
            send_sample(rch[mtd_pkg::CHAN_W-1:0], rs[mtd_pkg::SAMPLE_W-1:0]);
          end else begin
            send_sample(run_ch, pick_sample(kind));
          end
          sent++;
        end
      end
      drain();
    end

    drain();
    if (mismatches == 0)
      $display("PASS multichannel_touch_debouncer");
    else
      $display("FAIL multichannel_touch_debouncer");
    $finish;
  end

endmodule

// File: sim.f
hdl/mtd_pkg.sv
hdl/mtd_cfg_regs.sv
hdl/mtd_chan_update.sv
hdl/multichannel_touch_debouncer.sv
hdl/mtd_checker.sv
tb/sv/mtd_checker.sv
tb/sv/tb_top.sv
